@@ rtl/hxb_pkg.sv @@
// hxb_pkg: shared types and constants for the hex to base32/base64 re-encoder
`default_nettype none
package hxb_pkg;

  // item command codes
  typedef enum logic [1:0] {
    CMD_IN_LOAD  = 2'd0,
    CMD_OUT_LOAD = 2'd1,
    CMD_DATA     = 2'd2,
    CMD_RSVD     = 2'd3
  } hxb_cmd_t;

  localparam logic [2:0] GRP_B32 = 3'd5;
  localparam logic [2:0] GRP_B64 = 3'd6;
  localparam logic [3:0] NIBBLE  = 4'd4;
  localparam logic [1:0] Q_DEPTH = 2'd2;

  // one pending result: output alphabet index and end flag
  typedef struct packed {
    logic [5:0] grp;
    logic       eos;
  } hxb_grp_t;

  // what the packer hands back for one data word
  typedef struct packed {
    logic [1:0] num;
    hxb_grp_t   res_a;
    hxb_grp_t   res_b;
    logic [4:0] buf_nxt;
    logic [2:0] cnt_nxt;
  } hxb_pack_t;

endpackage
`default_nettype wire

@@ rtl/hxb_packer.sv @@
// hxb_packer: appends one hex digit to the bit buffer and cuts out groups
`default_nettype none
module hxb_packer import hxb_pkg::*; (
  input  wire logic       mode64,
  input  wire logic [4:0] bit_buf,
  input  wire logic [2:0] bit_cnt,
  input  wire logic [3:0] digit,
  input  wire logic       last,
  output hxb_pack_t       pack
);

  logic [2:0] g;
  logic [8:0] acc;
  logic [3:0] nc;
  logic       full;
  logic [3:0] rem;
  logic [8:0] grp_sh;
  logic [5:0] grp_full;
  logic [8:0] rem_mask;
  logic [4:0] rem_buf;
  logic [8:0] tail_sh;
  logic [5:0] grp_tail;
  logic       tail_en;

  always_comb begin
    g        = mode64 ? GRP_B64 : GRP_B32;
    acc      = {bit_buf, digit};
    nc       = {1'b0, bit_cnt} + NIBBLE;
    full     = (nc >= {1'b0, g});
    rem      = full ? (nc - {1'b0, g}) : nc;
    grp_sh   = acc >> (full ? rem : 4'd0);
    grp_full = mode64 ? grp_sh[5:0] : {1'b0, grp_sh[4:0]};
    rem_mask = (9'd1 << rem) - 9'd1;
    rem_buf  = acc[4:0] & rem_mask[4:0];
    // partial group padded with zeros at its low end
    tail_sh  = {4'd0, rem_buf} << ({1'b0, g} - rem);
    grp_tail = mode64 ? tail_sh[5:0] : {1'b0, tail_sh[4:0]};
    tail_en  = last && (rem != 4'd0);

    pack.res_a.grp = full ? grp_full : grp_tail;
    pack.res_a.eos = full ? (last && (rem == 4'd0)) : 1'b1;
    pack.res_b.grp = grp_tail;
    pack.res_b.eos = 1'b1;
    pack.num       = {1'b0, full} + {1'b0, tail_en};
    pack.buf_nxt   = last ? 5'd0 : rem_buf;
    pack.cnt_nxt   = last ? 3'd0 : rem[2:0];
  end

endmodule
`default_nettype wire

@@ rtl/hex_to_base32_64_reencoder_core.sv @@
// hex_to_base32_64_reencoder_core: top level of the hex to base32/base64 re-encoder
//
//   channel | ports                                          | dir
//   --------+------------------------------------------------+-----
//   in      | in_valid/in_ready, command, symbol, digit, last | in
//   out     | out_valid/out_ready, out_char, end_of_string    | out
//   cfg     | cfg_valid/cfg_ready, cfg_data (base64 mode)     | in
//
// one input word per cycle when in_ready; a data word gives 0, 1 or 2 result words
// result words leave at one per cycle while out_ready is high, as set by the single
// output alphabet read port; out_valid rises after read stage, queue and output reg
// an output alphabet load waits while data words are still in flight
// rst_n is synchronous; the input alphabet clears through per-entry valid bits
`default_nettype none
module hex_to_base32_64_reencoder_core import hxb_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_command,
  input  wire logic [7:0] in_symbol,
  input  wire logic [5:0] in_digit_index,
  input  wire logic       in_last,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_char,
  output logic            out_end_of_string,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       cfg_data
);

  // alphabets
  logic [3:0] imem [256];
  logic [255:0] ivld_r;
  logic [7:0] omem [64];

  // config
  logic mode64_r;

  // read stage
  logic       s1_valid_r;
  logic       s1_last_r;
  logic [3:0] s1_dig_r;
  logic       s1_vld_r;

  // bit accumulator
  logic [4:0] bbuf_r;
  logic [2:0] bcnt_r;

  // result queue
  hxb_grp_t   q0_r, q1_r, q0_nxt, q1_nxt;
  logic [1:0] q_cnt_r, q_cnt_nxt;

  // output register
  logic       out_valid_r;
  logic [7:0] out_char_r;
  logic       out_eos_r;

  logic      in_fire;
  logic      data_fire;
  logic      pending;
  logic      s1_move;
  logic      s1_fire;
  logic      s1_free;
  logic      out_ld;
  logic [3:0] digit;
  logic [2:0] q_fill;
  hxb_pack_t pack;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode64_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      mode64_r <= cfg_data;
    end
  end

  // handshake
  assign pending   = s1_valid_r || (q_cnt_r != 2'd0);
  assign s1_free   = !s1_valid_r || s1_move;
  assign in_ready  = s1_free && !((in_command == CMD_OUT_LOAD) && pending);
  assign in_fire   = in_valid && in_ready;
  assign data_fire = in_fire && (in_command == CMD_DATA);

  // input alphabet: write on load, registered read on data word
  always_ff @(posedge clk) begin
    if (in_fire && (in_command == CMD_IN_LOAD)) begin
      imem[in_symbol] <= in_digit_index[3:0];
    end
    if (data_fire) begin
      s1_dig_r <= imem[in_symbol];
      s1_vld_r <= ivld_r[in_symbol];
      s1_last_r <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ivld_r <= '0;
    end else if (in_fire && (in_command == CMD_IN_LOAD)) begin
      ivld_r[in_symbol] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_free) begin
      s1_valid_r <= data_fire;
    end
  end

  // never-loaded symbol reads as digit zero
  assign digit = s1_vld_r ? s1_dig_r : 4'd0;

  hxb_packer u_packer (
    .mode64  (mode64_r),
    .bit_buf (bbuf_r),
    .bit_cnt (bcnt_r),
    .digit   (digit),
    .last    (s1_last_r),
    .pack    (pack)
  );

  // read stage advances only when its results fit in the queue after this cycle's pop
  assign out_ld  = (q_cnt_r != 2'd0) && (!out_valid_r || out_ready);
  assign q_fill  = {1'b0, q_cnt_r} - {2'b00, out_ld} + {1'b0, pack.num};
  assign s1_move = (q_fill <= {1'b0, Q_DEPTH});
  assign s1_fire = s1_valid_r && s1_move;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bbuf_r <= 5'd0;
      bcnt_r <= 3'd0;
    end else if (s1_fire) begin
      bbuf_r <= pack.buf_nxt;
      bcnt_r <= pack.cnt_nxt;
    end
  end

  // queue: pop from the head, then append new results behind what is left
  always_comb begin
    q0_nxt    = q0_r;
    q1_nxt    = q1_r;
    q_cnt_nxt = q_cnt_r;
    if (out_ld) begin
      q0_nxt    = q1_r;
      q_cnt_nxt = q_cnt_r - 2'd1;
    end
    if (s1_fire) begin
      case (pack.num)
        2'd1: begin
          if (q_cnt_nxt == 2'd0) begin
            q0_nxt = pack.res_a;
          end else begin
            q1_nxt = pack.res_a;
          end
        end
        2'd2: begin
          q0_nxt = pack.res_a;
          q1_nxt = pack.res_b;
        end
        default: begin
        end
      endcase
      q_cnt_nxt = q_cnt_nxt + pack.num;
    end
  end

  always_ff @(posedge clk) begin
    q0_r <= q0_nxt;
    q1_r <= q1_nxt;
    if (!rst_n) begin
      q_cnt_r <= 2'd0;
    end else begin
      q_cnt_r <= q_cnt_nxt;
    end
  end

  // output alphabet: write on load, registered read into the output register
  always_ff @(posedge clk) begin
    if (in_fire && (in_command == CMD_OUT_LOAD)) begin
      omem[in_digit_index] <= in_symbol;
    end
    if (out_ld) begin
      out_char_r <= omem[q0_r.grp];
      out_eos_r  <= q0_r.eos;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_char          = out_char_r;
  assign out_end_of_string = out_eos_r;

  // queue never holds more than two results
  a_q_depth: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r != 2'd3)
    else $error("result queue overflow");

  // buffered bit count stays below the base64 group size
  a_bcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    bcnt_r <= 3'd5)
    else $error("bit count out of range");

  // a last data word flushes the accumulator
  a_flush: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_last_r |=> (bcnt_r == 3'd0) && (bbuf_r == 5'd0))
    else $error("accumulator not flushed after last");

  // output alphabet loads only land with no data word in flight
  a_oload_order: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_command == CMD_OUT_LOAD) |=> (q_cnt_r == 2'd0) && !s1_valid_r)
    else $error("output alphabet load overtook data");

endmodule
`default_nettype wire
